// ----- design/clcd_pkg.sv -----
// Shared types, command codes and LCD instruction constants for the
// character-LCD 4-bit command sequencer. No dependencies.
`default_nettype none

package clcd_pkg;

  // Command codes of the input transaction.
  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_CHAR  = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_POS   = 3'd3;
  localparam logic [2:0] CMD_DEC   = 3'd4;

  // LCD instruction bytes.
  localparam logic [7:0] LCD_FUNC_SET    = 8'h28;
  localparam logic [7:0] LCD_DISP_OFF    = 8'h08;
  localparam logic [7:0] LCD_CLEAR       = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] LCD_DISP_CURSOR = 8'h0e;
  localparam logic [7:0] LCD_DISP_PLAIN  = 8'h0c;
  localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
  localparam logic [6:0] LCD_ROW1_BASE   = 7'h40;
  localparam logic [7:0] ASCII_ZERO      = 8'h30;
  localparam logic [9:0] NUM_MAX         = 10'd999;

  // Wake-up nibble and the waits of the power-up sequence.
  localparam logic [3:0] WAKE_NIB  = 4'h3;
  localparam logic [3:0] MODE4_NIB = 4'h2;
  localparam logic [4:0] WAIT_NONE = 5'd0;
  localparam logic [4:0] WAIT_MIN  = 5'd1;
  localparam logic [4:0] WAIT_WAKE = 5'd5;
  localparam logic [4:0] WAIT_PWR  = 5'd15;
  localparam logic [4:0] WAIT_CLR  = 5'd21;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Kind of work the back end carries out.
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_INSTR = 2'd2,
    OP_DATA  = 2'd3
  } op_t;

  // One queued job: up to three data bytes, or one instruction byte.
  typedef struct packed {
    op_t             op;
    logic            cursor;
    logic [1:0]      count;
    logic [2:0][7:0] data;
  } job_t;

  // One bus write.
  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic [4:0] wait_ms;
    logic       last;
  } wr_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic [4:0] wait_ms;
  } nib_wait_t;

  // Queue status seen by the front, the back and the checks.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Clear screen: display control byte, then clear byte.
  function automatic nib_wait_t clear_write(input logic cursor, input logic [1:0] step);
    logic [7:0] ctl;
    nib_wait_t  nw;
    ctl = cursor ? LCD_DISP_CURSOR : LCD_DISP_PLAIN;
    case (step)
      2'd0:    nw = '{nibble: ctl[7:4],       wait_ms: WAIT_NONE};
      2'd1:    nw = '{nibble: ctl[3:0],       wait_ms: WAIT_MIN};
      2'd2:    nw = '{nibble: LCD_CLEAR[7:4], wait_ms: WAIT_NONE};
      default: nw = '{nibble: LCD_CLEAR[3:0], wait_ms: WAIT_CLR};
    endcase
    return nw;
  endfunction

  // Power-up sequence, ending in a clear screen with the cursor hidden.
  function automatic nib_wait_t init_write(input logic [3:0] step);
    nib_wait_t nw;
    case (step)
      4'd0:    nw = '{nibble: WAKE_NIB,             wait_ms: WAIT_PWR};
      4'd1:    nw = '{nibble: WAKE_NIB,             wait_ms: WAIT_WAKE};
      4'd2:    nw = '{nibble: WAKE_NIB,             wait_ms: WAIT_MIN};
      4'd3:    nw = '{nibble: MODE4_NIB,            wait_ms: WAIT_MIN};
      4'd4:    nw = '{nibble: LCD_FUNC_SET[7:4],    wait_ms: WAIT_NONE};
      4'd5:    nw = '{nibble: LCD_FUNC_SET[3:0],    wait_ms: WAIT_MIN};
      4'd6:    nw = '{nibble: LCD_DISP_OFF[7:4],    wait_ms: WAIT_NONE};
      4'd7:    nw = '{nibble: LCD_DISP_OFF[3:0],    wait_ms: WAIT_MIN};
      4'd8:    nw = '{nibble: LCD_CLEAR[7:4],       wait_ms: WAIT_NONE};
      4'd9:    nw = '{nibble: LCD_CLEAR[3:0],       wait_ms: WAIT_MIN};
      4'd10:   nw = '{nibble: LCD_ENTRY_MODE[7:4],  wait_ms: WAIT_NONE};
      4'd11:   nw = '{nibble: LCD_ENTRY_MODE[3:0],  wait_ms: WAIT_MIN};
      default: nw = clear_write(1'b0, step[1:0]);
    endcase
    return nw;
  endfunction

endpackage

`default_nettype wire

// ----- design/clcd_cmd_if.sv -----
// Command channel: valid/ready handshake with the command fields.
// No dependencies.
`default_nettype none

interface clcd_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  char_code;
  logic [5:0]  column;
  logic [1:0]  row;
  logic [15:0] number;
  logic        lead_zeros;
  logic        cursor_on;

  modport source (output valid, cmd, char_code, column, row, number, lead_zeros,
                  cursor_on, input ready);
  modport sink (input valid, cmd, char_code, column, row, number, lead_zeros,
                cursor_on, output ready);
endinterface

`default_nettype wire

// ----- design/clcd_bus_if.sv -----
// Bus write channel: valid/ready handshake with one 4-bit LCD write.
// No dependencies.
`default_nettype none

interface clcd_bus_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic [4:0] wait_ms;
  logic       last;

  modport source (output valid, reg_select, nibble, wait_ms, last, input ready);
  modport sink (input valid, reg_select, nibble, wait_ms, last, output ready);
endinterface

`default_nettype wire

// ----- design/clcd_front.sv -----
// Front end: accepts commands, splits numbers into digits, tracks the
// cursor column and pushes jobs into the queue. Uses clcd_pkg, clcd_cmd_if.
`default_nettype none

module clcd_front #(
  parameter int COLUMNS = 16
) (
  input  wire               clk,
  input  wire               rst,
  clcd_cmd_if.sink          cmd_in,
  input  clcd_pkg::q_status_t q_stat,
  output logic              push,
  output clcd_pkg::job_t    job
);

  // Stage one registers.
  logic       s1_valid;
  logic [2:0] s1_cmd;
  logic [7:0] s1_char;
  logic [5:0] s1_column;
  logic [1:0] s1_row;
  logic       s1_lz;
  logic       s1_cursor;
  logic [9:0] s1_num;
  logic [3:0] s1_hund;
  logic [6:0] s1_tens_q;

  // Cursor column.
  logic [5:0] cur_column;
  logic [5:0] cur_column_next;

  logic [9:0]  sat_num;
  logic [15:0] hund_prod;
  logic [17:0] tens_prod;
  logic        known;
  logic        s1_done;
  logic [9:0]  units_full;
  logic [6:0]  tens_full;
  logic [3:0]  units;
  logic [3:0]  tens;
  logic        show_h;
  logic        show_t;
  logic [5:0]  col1;
  logic [5:0]  col2;
  logic [5:0]  col3;
  logic [6:0]  addr;

  function automatic logic [5:0] wrap_inc(input logic [5:0] c);
    logic [5:0] b;
    b = ({1'b0, c} >= 7'(COLUMNS)) ? 6'd0 : c;
    return b + 6'd1;
  endfunction

  // Saturate, then take n/100 and n/10 by reciprocal multiplication.
  always_comb begin
    sat_num   = (cmd_in.number > {6'd0, clcd_pkg::NUM_MAX}) ? clcd_pkg::NUM_MAX
                                                            : cmd_in.number[9:0];
    hund_prod = 16'(sat_num) * 16'd41;
    tens_prod = 18'(sat_num) * 18'd205;
  end

  // Stage one moves on when it is empty, holds nothing to queue, or the queue has room.
  always_comb begin
    known   = s1_cmd inside {[clcd_pkg::CMD_INIT:clcd_pkg::CMD_DEC]};
    s1_done = s1_valid && (!known || !q_stat.full);
    push    = s1_valid && known && !q_stat.full;
  end

  assign cmd_in.ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_in.ready) begin
      s1_valid <= cmd_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.valid && cmd_in.ready) begin
      s1_cmd    <= cmd_in.cmd;
      s1_char   <= cmd_in.char_code;
      s1_column <= cmd_in.column;
      s1_row    <= cmd_in.row;
      s1_lz     <= cmd_in.lead_zeros;
      s1_cursor <= cmd_in.cursor_on;
      s1_num    <= sat_num;
      s1_hund   <= hund_prod[15:12];
      s1_tens_q <= tens_prod[17:11];
    end
  end

  // Digits and which of them are printed.
  always_comb begin
    units_full = s1_num - ({s1_tens_q, 3'd0} + {2'd0, s1_tens_q, 1'b0});
    tens_full  = s1_tens_q - ({s1_hund, 3'd0} + {2'd0, s1_hund, 1'b0});
    units      = units_full[3:0];
    tens       = tens_full[3:0];
    show_h     = s1_lz || (s1_hund != 4'd0);
    show_t     = show_h || (tens != 4'd0);
  end

  // Column after one, two and three printed characters.
  always_comb begin
    col1 = wrap_inc(cur_column);
    col2 = wrap_inc(col1);
    col3 = wrap_inc(col2);
  end

  // Build the job and the next column.
  always_comb begin
    job             = '0;
    cur_column_next = cur_column;
    addr            = {1'b0, cur_column};
    case (s1_cmd)
      clcd_pkg::CMD_INIT: begin
        job.op          = clcd_pkg::OP_INIT;
        cur_column_next = 6'd0;
      end
      clcd_pkg::CMD_CLEAR: begin
        job.op          = clcd_pkg::OP_CLEAR;
        job.cursor      = s1_cursor;
        cur_column_next = 6'd0;
      end
      clcd_pkg::CMD_CHAR: begin
        job.op          = clcd_pkg::OP_DATA;
        job.count       = 2'd1;
        job.data[0]     = s1_char;
        cur_column_next = col1;
      end
      clcd_pkg::CMD_POS: begin
        if (s1_row == 2'd0) begin
          addr = {1'b0, s1_column};
        end else if (s1_row == 2'd1) begin
          addr = clcd_pkg::LCD_ROW1_BASE | {1'b0, s1_column};
        end
        job.op          = clcd_pkg::OP_INSTR;
        job.count       = 2'd1;
        job.data[0]     = clcd_pkg::LCD_SET_DDRAM | {1'b0, addr};
        cur_column_next = s1_column;
      end
      clcd_pkg::CMD_DEC: begin
        job.op = clcd_pkg::OP_DATA;
        if (show_h) begin
          job.count       = 2'd3;
          job.data[0]     = clcd_pkg::ASCII_ZERO | {4'd0, s1_hund};
          job.data[1]     = clcd_pkg::ASCII_ZERO | {4'd0, tens};
          job.data[2]     = clcd_pkg::ASCII_ZERO | {4'd0, units};
          cur_column_next = col3;
        end else if (show_t) begin
          job.count       = 2'd2;
          job.data[0]     = clcd_pkg::ASCII_ZERO | {4'd0, tens};
          job.data[1]     = clcd_pkg::ASCII_ZERO | {4'd0, units};
          cur_column_next = col2;
        end else begin
          job.count       = 2'd1;
          job.data[0]     = clcd_pkg::ASCII_ZERO | {4'd0, units};
          cur_column_next = col1;
        end
      end
      default: begin
        cur_column_next = cur_column;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_column <= 6'd0;
    end else if (push) begin
      cur_column <= cur_column_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/clcd_queue.sv -----
// Short job queue between the front and back ends.
// Uses clcd_pkg.
`default_nettype none

module clcd_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  clcd_pkg::job_t      push_job,
  input  wire                 pop,
  output clcd_pkg::job_t      head,
  output clcd_pkg::q_status_t q_stat
);

  clcd_pkg::job_t             mem [clcd_pkg::QUEUE_DEPTH];
  logic [clcd_pkg::QPTR_W-1:0] wr_ptr;
  logic [clcd_pkg::QPTR_W-1:0] rd_ptr;
  logic [clcd_pkg::QPTR_W:0]   fill;

  assign q_stat.full  = (fill == (clcd_pkg::QPTR_W + 1)'(clcd_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign head         = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/clcd_back.sv -----
// Back end: steps through the head job one nibble write per cycle, while the bus takes
// them, into the output register. Uses clcd_pkg, clcd_bus_if.
`default_nettype none

module clcd_back (
  input  wire                 clk,
  input  wire                 rst,
  input  clcd_pkg::job_t      head,
  input  clcd_pkg::q_status_t q_stat,
  output logic                pop,
  clcd_bus_if.source          bus_out
);

  logic [3:0]        step;
  logic [3:0]        last_step;
  logic              advance;
  logic              out_valid;
  clcd_pkg::wr_t     out_wr;
  clcd_pkg::wr_t     wr;
  clcd_pkg::nib_wait_t nw;
  logic [7:0]        sel_byte;

  assign bus_out.valid      = out_valid;
  assign bus_out.reg_select = out_wr.reg_select;
  assign bus_out.nibble     = out_wr.nibble;
  assign bus_out.wait_ms    = out_wr.wait_ms;
  assign bus_out.last       = out_wr.last;

  assign advance = !q_stat.empty && (!out_valid || bus_out.ready);
  assign pop     = advance && (step == last_step);

  // Length of the head job and the write for the current step.
  always_comb begin
    sel_byte  = (head.op == clcd_pkg::OP_DATA) ? head.data[step[2:1]] : head.data[0];
    nw.nibble  = step[0] ? sel_byte[3:0] : sel_byte[7:4];
    nw.wait_ms = step[0] ? clcd_pkg::WAIT_MIN : clcd_pkg::WAIT_NONE;
    last_step = 4'd1;
    case (head.op)
      clcd_pkg::OP_INIT: begin
        last_step = 4'd15;
        nw        = clcd_pkg::init_write(step);
      end
      clcd_pkg::OP_CLEAR: begin
        last_step = 4'd3;
        nw        = clcd_pkg::clear_write(head.cursor, step[1:0]);
      end
      clcd_pkg::OP_DATA: begin
        last_step = {1'b0, head.count, 1'b0} - 4'd1;
      end
      default: begin
        last_step = 4'd1;
      end
    endcase
    wr.reg_select = (head.op == clcd_pkg::OP_DATA);
    wr.nibble     = nw.nibble;
    wr.wait_ms    = nw.wait_ms;
    wr.last       = (step == last_step);
  end

  // Step counter within the head job.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 4'd0;
    end else if (advance) begin
      step <= pop ? 4'd0 : step + 4'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || bus_out.ready) begin
      out_valid <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_wr <= wr;
    end
  end

endmodule

`default_nettype wire

// ----- design/char_lcd_4bit_command_sequencer_top.sv -----
// Top level: front end, job queue and back end of the 4-bit LCD sequencer.
// A command goes through the stage one register, the queue and the output register.
// Back end: one write per cycle while the bus takes them: init 16, clear 4, position 2,
// character 2, decimal 2 to 6. Commands are taken one per cycle while the queue has room.
// Synchronous reset empties the pipeline and queue and sets the column to 0.
`default_nettype none

module char_lcd_4bit_command_sequencer_top #(
  parameter int COLUMNS = 16
) (
  input  wire        clk,
  input  wire        rst,
  clcd_cmd_if.sink   cmd_in,
  clcd_bus_if.source bus_out
);

  clcd_pkg::job_t      push_job;
  clcd_pkg::job_t      head;
  clcd_pkg::q_status_t q_stat;
  logic                push;
  logic                pop;

  clcd_front #(.COLUMNS(COLUMNS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (cmd_in),
    .q_stat (q_stat),
    .push   (push),
    .job    (push_job)
  );

  clcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  clcd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .bus_out (bus_out)
  );

  // The front never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full) else $error("push into full queue");

  // The back never retires a job from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("pop from empty queue");

  // The long clear wait only ends a clear, as an instruction write.
  a_clear_wait: assert property (@(posedge clk) disable iff (rst)
    (bus_out.valid && bus_out.wait_ms == clcd_pkg::WAIT_CLR)
      |-> (bus_out.last && !bus_out.reg_select)) else $error("bad clear wait");

endmodule

`default_nettype wire

// ----- tb/tb_char_lcd_4bit_command_sequencer_top.sv -----
// Testbench for the 4-bit character-LCD command sequencer: drives commands, predicts
// every bus write and checks each one in order. Depends on clcd_pkg, clcd_cmd_if,
// clcd_bus_if and char_lcd_4bit_command_sequencer_top.
`timescale 1ns / 100ps

module tb_char_lcd_4bit_command_sequencer_top;

  localparam int LCD_COLUMNS = 16;
  localparam int RANDOM_CMDS = 350;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA = 1'b1;
  localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] CMD_RESERVED_LAST = 3'd7;

  // One command as the testbench queues it.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  char_code;
    logic [5:0]  column;
    logic [1:0]  row;
    logic [15:0] number;
    logic        lead_zeros;
    logic        cursor_on;
    logic        drain_first;
  } lcd_cmd_t;

  logic clk;
  logic rst;

  clcd_cmd_if cmd_in ();
  clcd_bus_if bus_out ();

  char_lcd_4bit_command_sequencer_top #(
    .COLUMNS(LCD_COLUMNS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_in(cmd_in),
    .bus_out(bus_out)
  );

  lcd_cmd_t       cmd_queue[$];
  lcd_cmd_t       cmd_now;
  clcd_pkg::wr_t  lcd_run[$];
  clcd_pkg::wr_t  bus_expect[$];
  clcd_pkg::wr_t  want;

  // Cursor state of the display as the sequencer should track it.
  logic [5:0] lcd_col;
  logic [1:0] lcd_row;

  int cmds_sent;
  int cmds_accepted;
  int writes_taken;
  int writes_noted;
  int send_gap;
  int send_calm;
  int stall_left;
  int recv_gap;
  int recv_calm;
  int idle_cycles;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wait draw for either side: mostly random, with occasional stretches of no waiting.
  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic lcd_cmd_t random_cmd(logic [2:0] op);
    lcd_cmd_t c;
    c.cmd = op;
    c.char_code = 8'($urandom_range(0, 255));
    c.column = 6'($urandom_range(0, 63));
    c.row = 2'($urandom_range(0, 3));
    c.number = 16'($urandom_range(0, 65535));
    c.lead_zeros = 1'($urandom_range(0, 1));
    c.cursor_on = 1'($urandom_range(0, 1));
    c.drain_first = 1'b0;
    return c;
  endfunction

  // Command mix weighted toward text output and cursor moves.
  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return clcd_pkg::CMD_INIT;
    if (r < 10) return clcd_pkg::CMD_CLEAR;
    if (r < 30) return clcd_pkg::CMD_POS;
    if (r < 65) return clcd_pkg::CMD_CHAR;
    if (r < 92) return clcd_pkg::CMD_DEC;
    return 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
  endfunction

  task automatic put_nibble(logic rs, logic [3:0] nib, logic [4:0] wait_ms);
    clcd_pkg::wr_t wr;
    wr.reg_select = rs;
    wr.nibble = nib;
    wr.wait_ms = wait_ms;
    wr.last = 1'b0;
    lcd_run.push_back(wr);
  endtask

  // A byte goes out high nibble first; only the low nibble carries the wait.
  task automatic put_byte(logic rs, logic [7:0] b, logic [4:0] wait_ms);
    put_nibble(rs, b[7:4], clcd_pkg::WAIT_NONE);
    put_nibble(rs, b[3:0], wait_ms);
  endtask

  task automatic clear_screen(logic cursor);
    put_byte(RS_INSTR, cursor ? clcd_pkg::LCD_DISP_CURSOR : clcd_pkg::LCD_DISP_PLAIN,
             clcd_pkg::WAIT_MIN);
    lcd_col = '0;
    lcd_row = '0;
    put_byte(RS_INSTR, clcd_pkg::LCD_CLEAR, clcd_pkg::WAIT_CLR);
  endtask

  // The column wraps to zero before writing once it has run off the screen.
  task automatic put_char(logic [7:0] code);
    if (lcd_col >= LCD_COLUMNS) lcd_col = '0;
    put_byte(RS_DATA, code, clcd_pkg::WAIT_MIN);
    lcd_col = lcd_col + 6'd1;
  endtask

  // Works out the bus writes of one accepted command and queues them.
  task automatic predict_writes(lcd_cmd_t c);
    logic [6:0] addr;
    int         value;
    int         div;
    int         digit;
    bit         show;
    lcd_run.delete();
    case (c.cmd)
      clcd_pkg::CMD_INIT: begin
        put_nibble(RS_INSTR, clcd_pkg::WAKE_NIB, clcd_pkg::WAIT_PWR);
        put_nibble(RS_INSTR, clcd_pkg::WAKE_NIB, clcd_pkg::WAIT_WAKE);
        put_nibble(RS_INSTR, clcd_pkg::WAKE_NIB, clcd_pkg::WAIT_MIN);
        put_nibble(RS_INSTR, clcd_pkg::MODE4_NIB, clcd_pkg::WAIT_MIN);
        put_byte(RS_INSTR, clcd_pkg::LCD_FUNC_SET, clcd_pkg::WAIT_MIN);
        put_byte(RS_INSTR, clcd_pkg::LCD_DISP_OFF, clcd_pkg::WAIT_MIN);
        put_byte(RS_INSTR, clcd_pkg::LCD_CLEAR, clcd_pkg::WAIT_MIN);
        put_byte(RS_INSTR, clcd_pkg::LCD_ENTRY_MODE, clcd_pkg::WAIT_MIN);
        clear_screen(1'b0);
      end
      clcd_pkg::CMD_CHAR: put_char(c.char_code);
      clcd_pkg::CMD_CLEAR: clear_screen(c.cursor_on);
      clcd_pkg::CMD_POS: begin
        // Rows above one keep the old column as the address.
        addr = {1'b0, lcd_col};
        lcd_col = c.column;
        lcd_row = c.row;
        if (c.row == 2'd0) addr = {1'b0, c.column};
        else if (c.row == 2'd1) addr = {1'b0, c.column} | clcd_pkg::LCD_ROW1_BASE;
        put_byte(RS_INSTR, clcd_pkg::LCD_SET_DDRAM | {1'b0, addr}, clcd_pkg::WAIT_MIN);
      end
      clcd_pkg::CMD_DEC: begin
        value = (c.number > clcd_pkg::NUM_MAX) ? int'(clcd_pkg::NUM_MAX) : int'(c.number);
        show = c.lead_zeros;
        for (div = 100; div > 0; div = div / 10) begin
          digit = value / div;
          if (div == 1) show = 1'b1;
          if (digit != 0 || show) begin
            put_char(clcd_pkg::ASCII_ZERO + 8'(digit));
            show = 1'b1;
          end
          value = value % div;
        end
      end
      default: ;
    endcase
    foreach (lcd_run[i]) begin
      if (i == lcd_run.size() - 1) lcd_run[i].last = 1'b1;
      bus_expect.push_back(lcd_run[i]);
    end
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("bus write field %s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Command driver: a new transaction once the previous one is taken and its gap is over.
  always @(negedge clk) begin
    if (rst) begin
      cmd_in.valid <= 1'b0;
      send_gap <= 0;
    end else if (!cmd_in.valid || cmds_accepted == cmds_sent) begin
      if (send_gap > 0) begin
        cmd_in.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (cmd_queue.size() > 0 &&
                   (!cmd_queue[0].drain_first || bus_expect.size() == 0)) begin
        cmd_now = cmd_queue.pop_front();
        cmd_in.cmd <= cmd_now.cmd;
        cmd_in.char_code <= cmd_now.char_code;
        cmd_in.column <= cmd_now.column;
        cmd_in.row <= cmd_now.row;
        cmd_in.number <= cmd_now.number;
        cmd_in.lead_zeros <= cmd_now.lead_zeros;
        cmd_in.cursor_on <= cmd_now.cursor_on;
        cmd_in.valid <= 1'b1;
        cmds_sent <= cmds_sent + 1;
        send_gap <= draw_idle(send_calm);
      end else begin
        cmd_in.valid <= 1'b0;
      end
    end
  end

  // Bus receiver: stalls for a random number of cycles, possibly none, after each taken write.
  always @(negedge clk) begin
    if (rst) begin
      bus_out.ready <= 1'b0;
      stall_left <= 0;
    end else if (writes_taken != writes_noted) begin
      recv_gap = draw_idle(recv_calm);
      writes_noted <= writes_taken;
      stall_left <= (recv_gap > 0) ? recv_gap - 1 : 0;
      bus_out.ready <= (recv_gap == 0);
    end else if (stall_left > 0) begin
      bus_out.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      bus_out.ready <= 1'b1;
    end
  end

  // Monitor: checks taken bus writes, predicts accepted commands, and watches for hangs.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (bus_out.valid && bus_out.ready) begin
        writes_taken <= writes_taken + 1;
        if (bus_expect.size() == 0) begin
          $error("bus write with nothing expected: rs %0d nibble %0d wait %0d last %0d",
                 bus_out.reg_select, bus_out.nibble, bus_out.wait_ms, bus_out.last);
          mismatches++;
        end else begin
          want = bus_expect.pop_front();
          check_field("reg_select", want.reg_select, bus_out.reg_select);
          check_field("nibble", want.nibble, bus_out.nibble);
          check_field("wait_ms", want.wait_ms, bus_out.wait_ms);
          check_field("last", want.last, bus_out.last);
        end
      end
      if (cmd_in.valid && cmd_in.ready) begin
        predict_writes(cmd_now);
        cmds_accepted <= cmds_accepted + 1;
      end
      if ((bus_out.valid && bus_out.ready) || (cmd_in.valid && cmd_in.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    lcd_cmd_t c;
    int       k;
    rst = 1'b1;
    cmd_in.valid = 1'b0;
    cmd_in.cmd = clcd_pkg::CMD_INIT;
    cmd_in.char_code = '0;
    cmd_in.column = '0;
    cmd_in.row = '0;
    cmd_in.number = '0;
    cmd_in.lead_zeros = 1'b0;
    cmd_in.cursor_on = 1'b0;
    bus_out.ready = 1'b0;
    lcd_col = '0;
    lcd_row = '0;
    cmds_sent = 0;
    cmds_accepted = 0;
    writes_taken = 0;
    writes_noted = 0;
    send_calm = 0;
    recv_gap = 0;
    recv_calm = 0;
    mismatches = 0;

    // Directed part: every command, field extremes, column wrap, rows above one.
    cmd_queue.push_back(random_cmd(clcd_pkg::CMD_INIT));
    c = random_cmd(clcd_pkg::CMD_CHAR); c.char_code = 8'h00; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_CHAR); c.char_code = 8'hff; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_CLEAR); c.cursor_on = 1'b1; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_CLEAR); c.cursor_on = 1'b0; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_POS); c.column = 6'd63; c.row = 2'd0; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_CHAR); c.char_code = 8'h41; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_POS); c.column = 6'd5; c.row = 2'd1; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_POS); c.column = 6'd0; c.row = 2'd2; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_POS); c.column = 6'd63; c.row = 2'd3; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_CHAR); c.char_code = 8'h55; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_DEC); c.number = 16'd0; c.lead_zeros = 1'b0;
    cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_DEC); c.number = 16'd0; c.lead_zeros = 1'b1;
    cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_DEC); c.number = 16'd7; c.lead_zeros = 1'b0;
    cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_DEC); c.number = 16'd42; c.lead_zeros = 1'b1;
    cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_DEC); c.number = 16'd100; c.lead_zeros = 1'b0;
    cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_DEC); c.number = 16'd999; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_DEC); c.number = 16'd1000; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_DEC); c.number = 16'hffff; c.lead_zeros = 1'b1;
    cmd_queue.push_back(c);
    for (k = CMD_RESERVED_FIRST; k <= CMD_RESERVED_LAST; k++) begin
      cmd_queue.push_back(random_cmd(3'(k)));
    end
    c = random_cmd(clcd_pkg::CMD_POS); c.column = 6'd14; c.row = 2'd0; cmd_queue.push_back(c);
    c = random_cmd(clcd_pkg::CMD_DEC); c.number = 16'd5; c.lead_zeros = 1'b1;
    cmd_queue.push_back(c);
    cmd_queue.push_back(random_cmd(clcd_pkg::CMD_INIT));

    // Random part; some commands hold back until the bus has drained.
    for (k = 0; k < RANDOM_CMDS; k++) begin
      c = random_cmd(pick_cmd());
      case ($urandom_range(0, 3))
        0: c.number = 16'($urandom_range(0, 9));
        1: c.number = 16'($urandom_range(10, 999));
        2: c.number = 16'($urandom_range(990, 1010));
        default: ;
      endcase
      c.drain_first = (k == 0) || ($urandom_range(0, 39) == 0);
      cmd_queue.push_back(c);
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (cmd_queue.size() != 0 || cmds_accepted != cmds_sent) @(negedge clk);
    while (bus_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
